@@ rtl/core/gtp_pkg.sv @@
// shared types, constants and glyph rom for the page framebuffer text renderer
package gtp_pkg;

    localparam int ADVANCE_X   = 6;
    localparam int LINE_STEP   = 10;
    localparam int ROW_LIMIT   = 255;
    localparam int QUEUE_DEPTH = 4;
    localparam int GLYPH_COLS  = 5;
    localparam int SLOT_COUNT  = 2 * GLYPH_COLS;

    localparam logic [7:0] CHAR_END     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [GLYPH_COLS-1:0][7:0] t_glyph;

    typedef struct packed {
        logic              draw;
        t_glyph            glyph;
        logic signed [9:0] cx;
        logic signed [9:0] cy;
    } t_cmd;

    function automatic t_glyph cols5(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c, input logic [7:0] d,
                                     input logic [7:0] e);
        return {e, d, c, b, a};
    endfunction

    function automatic t_glyph glyph_lookup(input logic [7:0] ch_in);
        logic [7:0] ch;
        t_glyph     g;
        ch = ch_in;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            ch = ch - 8'd32;
        end
        unique case (ch)
            8'h41: g = cols5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42: g = cols5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = cols5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = cols5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45: g = cols5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = cols5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = cols5(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
            8'h48: g = cols5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g = cols5(8'h41, 8'h41, 8'h7F, 8'h41, 8'h41);
            8'h4A: g = cols5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            8'h4B: g = cols5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g = cols5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g = cols5(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g = cols5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: g = cols5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g = cols5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = cols5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g = cols5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = cols5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = cols5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g = cols5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g = cols5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g = cols5(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
            8'h58: g = cols5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = cols5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            8'h5A: g = cols5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            8'h30: g = cols5(8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E);
            8'h31: g = cols5(8'h00, 8'h21, 8'h7F, 8'h01, 8'h00);
            8'h32: g = cols5(8'h23, 8'h45, 8'h49, 8'h51, 8'h21);
            8'h33: g = cols5(8'h42, 8'h41, 8'h51, 8'h69, 8'h46);
            8'h34: g = cols5(8'h18, 8'h28, 8'h48, 8'h7F, 8'h08);
            8'h35: g = cols5(8'h72, 8'h51, 8'h51, 8'h51, 8'h4E);
            8'h36: g = cols5(8'h1E, 8'h29, 8'h49, 8'h49, 8'h06);
            8'h37: g = cols5(8'h40, 8'h47, 8'h48, 8'h50, 8'h60);
            8'h38: g = cols5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = cols5(8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C);
            8'h5F: g = cols5(8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
            8'h2D: g = cols5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h2E: g = cols5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h3A: g = cols5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h2F: g = cols5(8'h03, 8'h0C, 8'h10, 8'h60, 8'h80);
            8'h20: g = cols5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            default: g = cols5(8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F);
        endcase
        return g;
    endfunction

endpackage

@@ rtl/core/glyph_text_to_page_framebuffer.sv @@
// top level of the 5x8 bitmap text renderer for a page-organized framebuffer
//
// Input channel: one character per transaction (i_valid / o_stall). The first
// character of a string sets i_string_start and carries the start position.
// Output channel: byte write transactions (o_valid / i_stall), each giving a
// framebuffer byte index and a mask to OR into it; o_last marks the final
// write of a character. A character with nothing to draw gives one transaction
// with index 0, mask 0 and o_last set.
// The front end updates the cursor and fetches the glyph in the cycle a
// character is taken, then hands it to a four-entry command queue. The back
// end turns one queued character into page masks and sends one write per
// cycle while i_stall is low. Each character gives one to ten byte writes, one
// per nonzero mask (five columns, up to two pages each); another queued
// character is loaded as the last write of the current one is issued.
// While i_stall is high the output register holds; the queue absorbs up to four
// further characters before o_stall rises.
// Reset clears the cursor to the origin, empties the queue and output, and
// holds text stopped until a character with i_string_start arrives.
module glyph_text_to_page_framebuffer #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_string_start,
    input  logic signed [8:0] i_start_x,
    input  logic signed [8:0] i_start_y,
    input  logic [7:0]        i_char_code,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [9:0]        o_byte_index,
    output logic [7:0]        o_set_mask,
    output logic              o_last
);
    import gtp_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic q_full, q_empty, q_pop, accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    gtp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_string_start (i_string_start),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_char_code    (i_char_code),
        .o_cmd          (front_cmd)
    );

    gtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gtp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (head_cmd),
        .i_cmd_empty  (q_empty),
        .o_cmd_pop    (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte_index (o_byte_index),
        .o_set_mask   (o_set_mask),
        .o_last       (o_last)
    );

    a_empty_write_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_set_mask == 8'h00) |-> (o_last && o_byte_index == 10'd0))
        else $error("empty write not marked as final");

    a_writes_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside the writes of one character");

    a_pop_only_when_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a command from an empty queue");

endmodule

@@ rtl/core/gtp_front.sv @@
// front end: cursor tracking, character classification and glyph fetch
module gtp_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_string_start,
    input  logic signed [8:0] i_start_x,
    input  logic signed [8:0] i_start_y,
    input  logic [7:0]        i_char_code,
    output gtp_pkg::t_cmd     o_cmd
);
    import gtp_pkg::*;

    localparam logic signed [10:0] X_WRAP = 11'(SCREEN_WIDTH - ADVANCE_X);
    localparam logic signed [9:0]  Y_STOP = 10'(SCREEN_HEIGHT - 8);

    logic signed [9:0]  r_cursor_x, r_cursor_y, r_line_left_x;
    logic               r_stopped;
    logic signed [9:0]  n_cursor_x, n_cursor_y, n_line_left_x;
    logic               n_stopped;
    logic signed [9:0]  cx, cy, llx;
    logic               stp, draw;
    logic signed [10:0] adv;

    function automatic logic signed [9:0] line_down_y(input logic signed [9:0] y);
        logic signed [10:0] s;
        s = {y[9], y} + 11'(LINE_STEP);
        if (s > 11'(ROW_LIMIT)) begin
            s = 11'(ROW_LIMIT);
        end
        return s[9:0];
    endfunction

    always_comb begin
        cx  = r_cursor_x;
        cy  = r_cursor_y;
        llx = r_line_left_x;
        stp = r_stopped;
        if (i_string_start) begin
            cx  = {i_start_x[8], i_start_x};
            cy  = {i_start_y[8], i_start_y};
            llx = {i_start_x[8], i_start_x};
            stp = 1'b0;
        end
        draw          = 1'b0;
        adv           = {cx[9], cx} + 11'(ADVANCE_X);
        n_cursor_x    = cx;
        n_cursor_y    = cy;
        n_line_left_x = llx;
        n_stopped     = stp;
        if (!stp) begin
            priority if (i_char_code == CHAR_END) begin
                n_stopped = 1'b1;
            end else if (i_char_code == CHAR_NEWLINE) begin
                n_cursor_y = line_down_y(cy);
                n_cursor_x = llx;
            end else begin
                draw = 1'b1;
                if (adv > X_WRAP) begin
                    n_cursor_x = llx;
                    n_cursor_y = line_down_y(cy);
                end else begin
                    n_cursor_x = adv[9:0];
                end
                if (n_cursor_y > Y_STOP) begin
                    n_stopped = 1'b1;
                end
            end
        end
        o_cmd.draw  = draw;
        o_cmd.glyph = draw ? glyph_lookup(i_char_code) : '0;
        o_cmd.cx    = cx;
        o_cmd.cy    = cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_line_left_x <= '0;
            r_stopped     <= 1'b1;
        end else if (i_accept) begin
            r_cursor_x    <= n_cursor_x;
            r_cursor_y    <= n_cursor_y;
            r_line_left_x <= n_line_left_x;
            r_stopped     <= n_stopped;
        end
    end

endmodule

@@ rtl/core/gtp_queue.sv @@
// short command queue between front and back end
module gtp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gtp_pkg::t_cmd i_data,
    input  logic          i_pop,
    output gtp_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import gtp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/gtp_back.sv @@
// back end: clips glyph columns into page masks and emits byte writes
module gtp_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gtp_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [9:0]    o_byte_index,
    output logic [7:0]    o_set_mask,
    output logic          o_last
);
    import gtp_pkg::*;

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;

    logic                           r_busy;
    logic [SLOT_COUNT-1:0]          r_vec;
    logic [SLOT_COUNT-1:0][7:0]     r_mask;
    logic signed [9:0]              r_cx;
    logic signed [6:0]              r_base;
    logic                           r_out_valid;
    logic [9:0]                     r_out_index;
    logic [7:0]                     r_out_mask;
    logic                           r_out_last;

    logic [SLOT_COUNT-1:0]          ld_vec;
    logic [SLOT_COUNT-1:0][7:0]     ld_mask;
    logic signed [6:0]              ld_base;
    logic signed [10:0]             px;
    logic                           col_ok;
    logic [15:0]                    sh;
    logic signed [7:0]              page;
    logic                           page_ok;
    logic [7:0]                     clip, part;

    logic [3:0]                     sel;
    logic [SLOT_COUNT-1:0]          remain;
    logic                           out_free, emit, emit_last, load;
    logic signed [7:0]              sel_page;
    logic signed [10:0]             sel_px;
    logic [11:0]                    sel_index;

    always_comb begin
        ld_base = i_cmd.cy[9:3];
        ld_vec  = '0;
        ld_mask = '0;
        px      = '0;
        col_ok  = 1'b0;
        sh      = '0;
        page    = '0;
        page_ok = 1'b0;
        clip    = '0;
        part    = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            px     = {i_cmd.cx[9], i_cmd.cx} + 11'(c);
            col_ok = (px >= 0) && (px < 11'(SCREEN_WIDTH));
            sh     = {8'h00, i_cmd.glyph[c]} << i_cmd.cy[2:0];
            for (int h = 0; h < 2; h++) begin
                page    = {ld_base[6], ld_base} + 8'(h);
                page_ok = (page >= 0) && (page < 8'(PAGE_COUNT));
                for (int b = 0; b < 8; b++) begin
                    clip[b] = ({1'b0, page[2:0], 3'(b)} < 7'(SCREEN_HEIGHT));
                end
                part = (h == 1) ? sh[15:8] : sh[7:0];
                if (i_cmd.draw && col_ok && page_ok) begin
                    ld_mask[2*c+h] = part & clip;
                end
                ld_vec[2*c+h] = (ld_mask[2*c+h] != 8'h00);
            end
        end
    end

    always_comb begin
        sel = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_vec[i]) begin
                sel = 4'(i);
            end
        end
        remain     = r_vec;
        remain[sel] = 1'b0;
        out_free   = !r_out_valid || !i_stall;
        emit       = r_busy && out_free;
        emit_last  = (remain == '0);
        load       = !i_cmd_empty && (!r_busy || (emit && emit_last));
        sel_page   = {r_base[6], r_base} + 8'(sel[0]);
        sel_px     = {r_cx[9], r_cx} + 11'(sel[3:1]);
        sel_index  = 12'(sel_page[2:0]) * 12'(SCREEN_WIDTH) + 12'(sel_px[7:0]);
    end

    assign o_cmd_pop    = load;
    assign o_valid      = r_out_valid;
    assign o_byte_index = r_out_index;
    assign o_set_mask   = r_out_mask;
    assign o_last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mask <= ld_mask;
            r_cx   <= i_cmd.cx;
            r_base <= ld_base;
        end
        if (emit) begin
            if (r_vec == '0) begin
                r_out_index <= '0;
                r_out_mask  <= '0;
            end else begin
                r_out_index <= sel_index[9:0];
                r_out_mask  <= r_mask[sel];
            end
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_vec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_vec  <= ld_vec;
            end else if (emit) begin
                r_vec <= remain;
                if (emit_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
